// ===== design/ordered_list_engine_macros.svh =====
// Assertion macros shared by the ordered list engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold on every rising clock edge out of reset
`define OLE_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OLE_ASSERT(label, clk, rst_n, cond, msg)
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ole_pkg.sv =====
// Package for the ordered list engine: operation and status codes,
// field widths, default sizes and the memory control struct. No dependencies.
`timescale 1ns / 1ps

package ole_pkg;

  // Default store geometry
  localparam int DEPTH_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int IDX_W   = 7;
  localparam int IDXB_W  = 6;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int CNT_O_W = 7;

  // Position reported when nothing matches (-1 in 7 bits)
  localparam logic [IDX_W-1:0] NO_POSITION = 7'h7F;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_FIND    = 3'd3,
    OP_TALLY   = 3'd4,
    OP_REVERSE = 3'd5,
    OP_UNIQUE  = 3'd6,
    OP_SWAP    = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Strobes from the sequencer to the store
  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

// ===== design/ole_if.sv =====
// Channel interfaces of the ordered list engine: request, result, config.
// Depends on ole_pkg for field widths.
`timescale 1ns / 1ps

interface ole_req_if;
  logic                              valid;
  logic                              ready;
  logic [ole_pkg::OP_W-1:0]          operation;
  logic signed [ole_pkg::IDX_W-1:0]  index;
  logic [ole_pkg::IDXB_W-1:0]        index_b;
  logic [ole_pkg::VAL_W-1:0]         value;
  modport source (output valid, operation, index, index_b, value, input ready);
  modport sink   (input valid, operation, index, index_b, value, output ready);
endinterface

interface ole_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ole_pkg::ST_W-1:0]          status;
  logic signed [ole_pkg::IDX_W-1:0]  position;
  logic [ole_pkg::CNT_O_W-1:0]       match_count;
  logic [ole_pkg::CNT_O_W-1:0]       entry_total;
  modport source (output valid, status, position, match_count, entry_total, input ready);
  modport sink   (input valid, status, position, match_count, entry_total, output ready);
endinterface

interface ole_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ole_pkg::CNT_O_W-1:0]       data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/ordered_list_engine.sv =====
// Channel    | Dir | Carries
// req_i      | in  | operation, index, index_b, value
// rsp_o      | out | status, position, match_count, entry_total
// cfg_i      | in  | max_entries write data
//
// One item at a time. Append and out-of-range items need no store read;
// find and tally stream one store read a cycle; remove and insert walk the
// entries between the index and the count. Unique is a search then a
// compaction pass. Reverse and swap exchange pairs through the single
// store read port. Reset clears the count; the store is not cleared. A
// stalled result holds in its register and blocks the next result.
// Depends on ole_pkg, ole_if, ole_store and ordered_list_engine_macros.svh.
`timescale 1ns / 1ps
`include "ordered_list_engine_macros.svh"

module ordered_list_engine #(
  parameter int DEPTH      = ole_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = ole_pkg::VALUE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ole_req_if.sink  req_i,
  ole_rsp_if.source rsp_o,
  ole_cfg_if.sink  cfg_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > ole_pkg::IDX_W) ? CW : ole_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PACK = 3'd2;
  localparam logic [2:0] S_SHUP = 3'd3;
  localparam logic [2:0] S_SHDN = 3'd4;
  localparam logic [2:0] S_PAIR = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Control state
  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [ole_pkg::CNT_O_W-1:0] max_q, max_d;
  logic                    ov_q, ov_d;
  logic                    dv_q;
  logic [1:0]              ph_q, ph_d;

  // Working registers
  logic [CW-1:0]           p_q, p_d;
  logic [CW-1:0]           w_q, w_d;
  logic [CW-1:0]           n_q, n_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           mc_q, mc_d;
  logic [AW-1:0]           ta_q;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [VALUE_BITS-1:0]   tmp_q, tmp_d;
  ole_pkg::op_e            op_q, op_d;
  ole_pkg::status_e        st_q, st_d;
  logic [ole_pkg::IDX_W-1:0] pos_q, pos_d;

  // Result register
  ole_pkg::status_e        o_st_q;
  logic [ole_pkg::IDX_W-1:0]   o_pos_q;
  logic [ole_pkg::CNT_O_W-1:0] o_mc_q, o_tot_q;
  logic                    load_out;

  // Store port
  ole_pkg::mem_ctl_t       ctl;
  logic [AW-1:0]           raddr, waddr;
  logic [VALUE_BITS-1:0]   wdata, rdata;

  // Request decode
  logic                    in_fire;
  logic                    idx_neg, full, hit;
  logic [KW-1:0]           cnt_k, idx_k, idxb_k, lim_k;
  logic [VALUE_BITS-1:0]   val_in;
  logic [CW-1:0]           idx_c, idxb_c;

  ole_store #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign idx_neg = req_i.index[ole_pkg::IDX_W-1];
  assign cnt_k   = KW'(cnt_q);
  assign idx_k   = KW'(req_i.index[ole_pkg::IDX_W-1:0]);
  assign idxb_k  = KW'(req_i.index_b);
  assign lim_k   = (KW'(max_q) < KW'(DEPTH)) ? KW'(max_q) : KW'(DEPTH);
  assign full    = (cnt_k >= lim_k);
  assign val_in  = VALUE_BITS'(req_i.value);
  assign idx_c   = CW'(req_i.index[ole_pkg::IDXB_W-1:0]);
  assign idxb_c  = CW'(req_i.index_b);
  assign hit     = dv_q && (rdata == val_q);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ph_d     = ph_q;
    p_d      = p_q;
    w_d      = w_q;
    n_d      = n_q;
    idx_d    = idx_q;
    mc_d     = mc_q;
    val_d    = val_q;
    tmp_d    = tmp_q;
    op_d     = op_q;
    st_d     = st_q;
    pos_d    = pos_q;
    ctl      = '0;
    raddr    = p_q[AW-1:0];
    waddr    = p_q[AW-1:0];
    wdata    = rdata;
    load_out = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = ole_pkg::op_e'(req_i.operation);
          val_d   = val_in;
          st_d    = ole_pkg::ST_OK;
          pos_d   = ole_pkg::NO_POSITION;
          mc_d    = '0;
          idx_d   = idx_c;
          state_d = S_DONE;
          unique case (ole_pkg::op_e'(req_i.operation))
            ole_pkg::OP_APPEND: begin
              if (full) begin
                st_d = ole_pkg::ST_FULL;
              end else begin
                ctl.we = 1'b1;
                waddr  = cnt_q[AW-1:0];
                wdata  = val_in;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            ole_pkg::OP_INSERT: begin
              if (full) begin
                st_d = ole_pkg::ST_FULL;
              end else if (idx_neg || (idx_k > cnt_k)) begin
                st_d = ole_pkg::ST_RANGE;
              end else begin
                p_d     = cnt_q - CW'(1);
                n_d     = cnt_q - idx_c;
                state_d = S_SHUP;
              end
            end
            ole_pkg::OP_REMOVE: begin
              if (req_i.index[ole_pkg::IDX_W-1:0] == ole_pkg::NO_POSITION) begin
                st_d = ole_pkg::ST_OK;
              end else if (idx_neg || (idx_k >= cnt_k)) begin
                st_d = ole_pkg::ST_RANGE;
              end else begin
                p_d     = idx_c + CW'(1);
                n_d     = cnt_q - idx_c - CW'(1);
                state_d = S_SHDN;
              end
            end
            ole_pkg::OP_FIND, ole_pkg::OP_TALLY, ole_pkg::OP_UNIQUE: begin
              p_d     = '0;
              n_d     = cnt_q;
              state_d = S_SCAN;
            end
            ole_pkg::OP_REVERSE: begin
              if (cnt_q > CW'(1)) begin
                p_d     = '0;
                w_d     = cnt_q - CW'(1);
                ph_d    = 2'd0;
                state_d = S_PAIR;
              end
            end
            ole_pkg::OP_SWAP: begin
              if (idx_neg || (idx_k >= cnt_k) || (idxb_k >= cnt_k)) begin
                st_d = ole_pkg::ST_RANGE;
              end else begin
                p_d     = idx_c;
                w_d     = idxb_c;
                ph_d    = 2'd0;
                state_d = S_PAIR;
              end
            end
          endcase
        end
      end

      // Linear search: find stops at first hit, tally counts all hits, unique packs after first hit
      S_SCAN: begin
        if (hit && (op_q == ole_pkg::OP_FIND)) begin
          pos_d   = ole_pkg::IDX_W'(ta_q);
          state_d = S_DONE;
        end else if (hit && (op_q == ole_pkg::OP_UNIQUE)) begin
          p_d     = CW'(ta_q) + CW'(1);
          w_d     = CW'(ta_q) + CW'(1);
          n_d     = cnt_q - CW'(ta_q) - CW'(1);
          state_d = S_PACK;
        end else begin
          if (hit) begin
            mc_d = mc_q + CW'(1);
          end
          if (n_q != '0) begin
            ctl.re = 1'b1;
            p_d    = p_q + CW'(1);
            n_d    = n_q - CW'(1);
          end else if (!dv_q) begin
            state_d = S_DONE;
          end
        end
      end

      // Compaction: later copies of the value are dropped
      S_PACK: begin
        if (dv_q && !hit) begin
          ctl.we = 1'b1;
          waddr  = w_q[AW-1:0];
          w_d    = w_q + CW'(1);
        end
        if (n_q != '0) begin
          ctl.re = 1'b1;
          p_d    = p_q + CW'(1);
          n_d    = n_q - CW'(1);
        end else if (!dv_q) begin
          cnt_d   = w_q;
          state_d = S_DONE;
        end
      end

      // Insert: walk down, each entry moves one slot up, then place the value
      S_SHUP: begin
        if (dv_q) begin
          ctl.we = 1'b1;
          waddr  = ta_q + AW'(1);
        end
        if (n_q != '0) begin
          ctl.re = 1'b1;
          p_d    = p_q - CW'(1);
          n_d    = n_q - CW'(1);
        end else if (!dv_q) begin
          ctl.we  = 1'b1;
          waddr   = idx_q[AW-1:0];
          wdata   = val_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = S_DONE;
        end
      end

      // Remove: walk up, each entry moves one slot down
      S_SHDN: begin
        if (dv_q) begin
          ctl.we = 1'b1;
          waddr  = ta_q - AW'(1);
        end
        if (n_q != '0) begin
          ctl.re = 1'b1;
          p_d    = p_q + CW'(1);
          n_d    = n_q - CW'(1);
        end else if (!dv_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end
      end

      // Pair exchange: read the first entry, read the second, write the first, write the second
      S_PAIR: begin
        unique case (ph_q)
          2'd0: begin
            ctl.re = 1'b1;
            ph_d   = 2'd1;
          end
          2'd1: begin
            ctl.re = 1'b1;
            raddr  = w_q[AW-1:0];
            tmp_d  = rdata;
            ph_d   = 2'd2;
          end
          2'd2: begin
            ctl.we = 1'b1;
            ph_d   = 2'd3;
          end
          default: begin
            ctl.we = 1'b1;
            waddr  = w_q[AW-1:0];
            wdata  = tmp_q;
            if ((op_q == ole_pkg::OP_REVERSE) && ((p_q + CW'(2)) < w_q)) begin
              ctl.re = 1'b1;
              raddr  = p_q[AW-1:0] + AW'(1);
              p_d    = p_q + CW'(1);
              w_d    = w_q - CW'(1);
              ph_d   = 2'd1;
            end else begin
              state_d = S_DONE;
            end
          end
        endcase
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Config register and output valid
  always_comb begin
    max_d = max_q;
    if (cfg_i.valid && cfg_i.ready) begin
      max_d = cfg_i.data;
    end
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (rsp_o.ready) begin
      ov_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      max_q   <= ole_pkg::CNT_O_W'(64);
      ov_q    <= 1'b0;
      dv_q    <= 1'b0;
      ph_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      max_q   <= max_d;
      ov_q    <= ov_d;
      dv_q    <= ctl.re;
      ph_q    <= ph_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    w_q   <= w_d;
    n_q   <= n_d;
    idx_q <= idx_d;
    mc_q  <= mc_d;
    val_q <= val_d;
    tmp_q <= tmp_d;
    op_q  <= op_d;
    st_q  <= st_d;
    pos_q <= pos_d;
    if (ctl.re) begin
      ta_q <= raddr;
    end
    if (load_out) begin
      o_st_q  <= st_q;
      o_pos_q <= pos_q;
      o_mc_q  <= ole_pkg::CNT_O_W'(mc_q);
      o_tot_q <= ole_pkg::CNT_O_W'(cnt_q);
    end
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = o_st_q;
  assign rsp_o.position    = o_pos_q;
  assign rsp_o.match_count = o_mc_q;
  assign rsp_o.entry_total = o_tot_q;

  // Checks
  `OLE_ASSERT(a_cnt_bound, clk_i, rst_ni, KW'(cnt_q) <= KW'(DEPTH), "entry count above depth")
  `OLE_ASSERT(a_port_clash, clk_i, rst_ni, !(ctl.re && ctl.we && (raddr == waddr)), "read and write hit one entry")
  `OLE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, state_q != S_IDLE, "item accepted but sequencer idle")
  `OLE_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, load_out, ov_q, "result load lost")

endmodule

// ===== design/ole_store.sv =====
// List store: one write port, one read port, read data registered.
// Depends on ole_pkg for the control struct.
`timescale 1ns / 1ps

module ole_store #(
  parameter int DEPTH      = ole_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = ole_pkg::VALUE_BITS_DEF,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  ole_pkg::mem_ctl_t     ctl_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [VALUE_BITS-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  // Synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for ordered_list_engine: directed and random list
// operations scored against an in-bench list predictor. Depends on ole_pkg,
// ole_if and the engine RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH     = 64;
  localparam int CYC_LIMIT = 2000000;

  typedef struct packed {
    logic [ole_pkg::ST_W-1:0]    status;
    logic [ole_pkg::IDX_W-1:0]   position;
    logic [ole_pkg::CNT_O_W-1:0] match_count;
    logic [ole_pkg::CNT_O_W-1:0] entry_total;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ole_req_if req_if();
  ole_rsp_if rsp_if();
  ole_cfg_if cfg_if();

  ordered_list_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state
  logic [31:0]  list_mirror[DEPTH];
  int           list_len;
  int           cap_limit;
  list_result_t pending_results[$];
  int           fail_count = 0;
  int           cyc_count = 0;
  int           idle_pct;

  // Stall control on the result side
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    if (cyc_count > CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i + 1];
    list_mirror[list_len - 1] = '0;
    list_len--;
  endfunction

  // Work out the result of one operation and update the mirror
  function automatic list_result_t apply_list_op(ole_pkg::op_e op, logic signed [6:0] idx,
                                                 logic [5:0] idx_b, logic [31:0] val);
    list_result_t r;
    int ix;
    int first;
    logic [31:0] t;
    ix = idx;
    r.status = ole_pkg::ST_OK;
    r.position = ole_pkg::NO_POSITION;
    r.match_count = '0;
    case (op)
      ole_pkg::OP_APPEND: begin
        if (list_len >= cap_limit) r.status = ole_pkg::ST_FULL;
        else begin
          list_mirror[list_len] = val;
          list_len++;
        end
      end
      ole_pkg::OP_INSERT: begin
        if (list_len >= cap_limit) r.status = ole_pkg::ST_FULL;
        else if (ix < 0 || ix > list_len) r.status = ole_pkg::ST_RANGE;
        else begin
          for (int i = list_len; i > ix; i--) list_mirror[i] = list_mirror[i - 1];
          list_mirror[ix] = val;
          list_len++;
        end
      end
      ole_pkg::OP_REMOVE: begin
        if (ix != -1) begin
          if (ix < 0 || ix >= list_len) r.status = ole_pkg::ST_RANGE;
          else drop_entry(ix);
        end
      end
      ole_pkg::OP_FIND: begin
        for (int i = 0; i < list_len; i++)
          if (list_mirror[i] == val) begin
            r.position = ole_pkg::IDX_W'(i);
            break;
          end
      end
      ole_pkg::OP_TALLY: begin
        for (int i = 0; i < list_len; i++)
          if (list_mirror[i] == val) r.match_count++;
      end
      ole_pkg::OP_REVERSE: begin
        for (int i = 0; i < list_len / 2; i++) begin
          t = list_mirror[i];
          list_mirror[i] = list_mirror[list_len - 1 - i];
          list_mirror[list_len - 1 - i] = t;
        end
      end
      ole_pkg::OP_UNIQUE: begin
        first = 0;
        while (first < list_len && list_mirror[first] != val) first++;
        for (int i = list_len; i > first + 1; i--)
          if (list_mirror[i - 1] == val) drop_entry(i - 1);
      end
      default: begin
        if (ix < 0 || ix >= list_len || int'(idx_b) >= list_len) r.status = ole_pkg::ST_RANGE;
        else begin
          t = list_mirror[ix];
          list_mirror[ix] = list_mirror[idx_b];
          list_mirror[idx_b] = t;
        end
      end
    endcase
    r.entry_total = ole_pkg::CNT_O_W'(list_len);
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_if.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.position !== exp_r.position) begin
          $error("position expected %0h actual %0h", exp_r.position, rsp_if.position);
          fail_count++;
        end
        if (rsp_if.match_count !== exp_r.match_count) begin
          $error("match_count expected %0d actual %0d", exp_r.match_count,
                 rsp_if.match_count);
          fail_count++;
        end
        if (rsp_if.entry_total !== exp_r.entry_total) begin
          $error("entry_total expected %0d actual %0d", exp_r.entry_total,
                 rsp_if.entry_total);
          fail_count++;
        end
      end
    end
  end

  // Send one item; expectation is queued at acceptance. Valid stays up after
  // acceptance until the next item or an idle cycle replaces it.
  task automatic send_item(ole_pkg::op_e op, logic signed [6:0] idx, logic [5:0] idx_b,
                           logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.index     <= idx;
    req_if.index_b   <= idx_b;
    req_if.value     <= val;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(apply_list_op(op, idx, idx_b, val));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Register write while idle
  task automatic write_limit(int lim);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= ole_pkg::CNT_O_W'(lim);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cap_limit = (lim < DEPTH) ? lim : DEPTH;
  endtask

  // Value pool kept small so matches are frequent
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(7);
    endcase
  endfunction

  function automatic logic signed [6:0] pick_index();
    case ($urandom_range(9))
      0: return 7'sh7F;
      1: return 7'($urandom);
      default: return 7'($urandom_range(list_len < 64 ? list_len : 63));
    endcase
  endfunction

  task automatic test_directed();
    write_limit(4);
    send_item(ole_pkg::OP_FIND, 0, 0, 32'h5);
    send_item(ole_pkg::OP_TALLY, 0, 0, 32'h5);
    send_item(ole_pkg::OP_REMOVE, 0, 0, 0);
    send_item(ole_pkg::OP_REMOVE, -1, 0, 0);
    send_item(ole_pkg::OP_APPEND, 0, 0, 32'hFFFF_FFFF);
    send_item(ole_pkg::OP_INSERT, 0, 0, 32'h0);
    send_item(ole_pkg::OP_INSERT, 5, 0, 32'h1);
    send_item(ole_pkg::OP_INSERT, -2, 0, 32'h1);
    send_item(ole_pkg::OP_APPEND, 0, 0, 32'h0);
    send_item(ole_pkg::OP_APPEND, 0, 0, 32'hA5A5_5A5A);
    send_item(ole_pkg::OP_APPEND, 0, 0, 32'h1);
    send_item(ole_pkg::OP_INSERT, 0, 0, 32'h1);
    send_item(ole_pkg::OP_FIND, 0, 0, 32'h0);
    send_item(ole_pkg::OP_TALLY, 0, 0, 32'h0);
    send_item(ole_pkg::OP_UNIQUE, 0, 0, 32'h0);
    send_item(ole_pkg::OP_UNIQUE, 0, 0, 32'h77);
    send_item(ole_pkg::OP_REVERSE, 0, 0, 0);
    send_item(ole_pkg::OP_SWAP, 0, 2, 0);
    send_item(ole_pkg::OP_SWAP, 3, 0, 0);
    send_item(ole_pkg::OP_SWAP, -1, 63, 0);
    send_item(ole_pkg::OP_REMOVE, 63, 0, 0);
    send_item(ole_pkg::OP_REMOVE, 2, 0, 0);
    // Limit lowered below count, then zero
    write_limit(1);
    send_item(ole_pkg::OP_APPEND, 0, 0, 32'h2);
    write_limit(0);
    send_item(ole_pkg::OP_INSERT, 0, 0, 32'h2);
  endtask

  task automatic random_burst(int n, int lim);
    ole_pkg::op_e op;
    write_limit(lim);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_drained();
      // Weight growth so the list fills up at the larger limits
      if ($urandom_range(99) < 35) begin
        op = $urandom_range(1) ? ole_pkg::OP_APPEND : ole_pkg::OP_INSERT;
      end else begin
        op = ole_pkg::op_e'($urandom_range(7));
      end
      send_item(op, pick_index(), 6'($urandom), pick_value());
    end
  endtask

  task automatic test_random();
    idle_pct = 0;
    random_burst(150, 64);
    idle_pct = 31;
    random_burst(400, 64);
    random_burst(250, 127);
    random_burst(250, 5);
    random_burst(200, 1);
    random_burst(200, 33);
    random_burst(200, 100);
  endtask

  initial begin
    idle_pct = 31;
    list_len = 0;
    cap_limit = 64;
    for (int i = 0; i < DEPTH; i++) list_mirror[i] = '0;
    req_if.valid = 1'b0;
    req_if.operation = '0;
    req_if.index = '0;
    req_if.index_b = '0;
    req_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    wait_drained();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
